// ===== rtl/core/tfp_pkg.sv =====
`default_nettype none

package tfp_pkg;

  // frame state widths
  localparam int COUNT_BITS    = 12;
  localparam int DATA_COUNT_W  = 12;
  localparam int CHECK_W       = 10;
  localparam int SUM_W         = 8;
  localparam int CHAR_W        = 8;
  localparam int OUT_COUNT_MAX = (1 << DATA_COUNT_W) - 1;
  localparam int CHECK_MAX     = 1023;
  localparam int PREFIX_LEN    = 3;

  // queue between classifier and frame engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // framing characters
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_AMP    = 8'h26;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h4E;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h4F;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_HASH,
    CLS_AMP,
    CLS_LBRACE,
    CLS_RBRACE,
    CLS_DIGIT
  } tfp_cls_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_SEQ    = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_ACCEPT = 3'd3,
    KIND_REJECT = 3'd4
  } tfp_kind_t;

  typedef struct packed {
    tfp_cls_t          cls;
    logic [CHAR_W-1:0] chr;
  } tfp_tok_t;

  // expected prefix text, one character per position
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      2'd0:    c = CH_N;
      2'd1:    c = CH_O;
      2'd2:    c = CH_EQ;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tfp_front.sv =====
`default_nettype none

module tfp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_chr,
  output logic                  tok_valid,
  input  wire logic             tok_ready,
  output tfp_pkg::tfp_tok_t     tok
);
  import tfp_pkg::*;

  logic     valid_r;
  tfp_tok_t tok_r;
  tfp_tok_t tok_nxt;

  assign in_ready  = !valid_r || tok_ready;
  assign tok_valid = valid_r;
  assign tok       = tok_r;

  // character classification
  always_comb begin
    tok_nxt.chr = in_chr;
    if (in_chr == CH_HASH) begin
      tok_nxt.cls = CLS_HASH;
    end else if (in_chr == CH_AMP) begin
      tok_nxt.cls = CLS_AMP;
    end else if (in_chr == CH_LBRACE) begin
      tok_nxt.cls = CLS_LBRACE;
    end else if (in_chr == CH_RBRACE) begin
      tok_nxt.cls = CLS_RBRACE;
    end else if (in_chr inside {[CH_ZERO:CH_NINE]}) begin
      tok_nxt.cls = CLS_DIGIT;
    end else begin
      tok_nxt.cls = CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfp_queue.sv =====
`default_nettype none

module tfp_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire tfp_pkg::tfp_tok_t push_tok,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output tfp_pkg::tfp_tok_t     pop_tok
);
  import tfp_pkg::*;

  tfp_tok_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push;
  logic                pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfp_back.sv =====
`default_nettype none

module tfp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        tok_valid,
  output logic                             tok_ready,
  input  wire tfp_pkg::tfp_tok_t           tok,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output tfp_pkg::tfp_kind_t               res_kind,
  output logic [7:0]                       res_chr,
  output logic [tfp_pkg::DATA_COUNT_W-1:0] res_count,
  output logic                             res_good
);
  import tfp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SEQ,
    PH_DATA,
    PH_CHECK
  } phase_t;

  localparam int CW_W = COUNT_BITS + DATA_COUNT_W;

  phase_t                  phase_r, phase_nxt;
  logic [1:0]              pos_r, pos_nxt;
  logic                    matched_r, matched_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [CHECK_W-1:0]      check_r, check_nxt;
  logic                    done_r, done_nxt;
  logic [COUNT_BITS-1:0]   count_r, count_nxt;

  logic                    out_valid_r;
  tfp_kind_t               out_kind_r, kind_nxt;
  logic [CHAR_W-1:0]       out_chr_r, chr_nxt;
  logic [DATA_COUNT_W-1:0] out_count_r, ocount_nxt;
  logic                    out_good_r, good_nxt;

  logic                    pop;
  logic                    verdict_good;
  logic [DATA_COUNT_W-1:0] verdict_count;
  logic [CW_W-1:0]         count_wide;
  logic [13:0]             check_mul;

  assign pop       = tok_valid && (!out_valid_r || res_ready);
  assign tok_ready = !out_valid_r || res_ready;

  assign res_valid = out_valid_r;
  assign res_kind  = out_kind_r;
  assign res_chr   = out_chr_r;
  assign res_count = out_count_r;
  assign res_good  = out_good_r;

  assign verdict_good  = matched_r && (pos_r == 2'(PREFIX_LEN));
  assign count_wide    = {{DATA_COUNT_W{1'b0}}, count_r};
  assign verdict_count = (count_wide > CW_W'(OUT_COUNT_MAX)) ?
                         DATA_COUNT_W'(OUT_COUNT_MAX) : count_wide[DATA_COUNT_W-1:0];
  // check * 10 + digit
  assign check_mul = {1'b0, check_r, 3'b000} + {3'b000, check_r, 1'b0}
                   + {10'd0, tok.chr[3:0]};

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    matched_nxt = matched_r;
    sum_nxt     = sum_r;
    check_nxt   = check_r;
    done_nxt    = done_r;
    count_nxt   = count_r;
    kind_nxt    = KIND_NONE;
    chr_nxt     = '0;
    ocount_nxt  = '0;
    good_nxt    = 1'b0;

    if (tok.cls == CLS_HASH) begin
      phase_nxt   = PH_SEQ;
      pos_nxt     = '0;
      matched_nxt = 1'b1;
      sum_nxt     = '0;
      check_nxt   = '0;
      done_nxt    = 1'b0;
      count_nxt   = '0;
    end else begin
      case (phase_r)
        PH_SEQ: begin
          if (tok.cls == CLS_AMP) begin
            phase_nxt  = PH_IDLE;
            kind_nxt   = KIND_REJECT;
            ocount_nxt = verdict_count;
            good_nxt   = verdict_good;
          end else if (tok.cls == CLS_LBRACE) begin
            if (pos_r != 2'(PREFIX_LEN)) begin
              matched_nxt = 1'b0;
            end
            phase_nxt = PH_DATA;
          end else if (pos_r != 2'(PREFIX_LEN)) begin
            if (tok.chr != prefix_char(pos_r)) begin
              matched_nxt = 1'b0;
            end
            pos_nxt = pos_r + 1'b1;
          end else begin
            kind_nxt = KIND_SEQ;
            chr_nxt  = tok.chr;
          end
        end
        PH_DATA: begin
          if (tok.cls == CLS_AMP) begin
            phase_nxt  = PH_IDLE;
            kind_nxt   = KIND_REJECT;
            ocount_nxt = verdict_count;
            good_nxt   = verdict_good;
          end else if (tok.cls == CLS_RBRACE) begin
            phase_nxt = PH_CHECK;
          end else begin
            sum_nxt = sum_r + tok.chr;
            if (count_r != '1) begin
              count_nxt = count_r + 1'b1;
            end
            kind_nxt = KIND_DATA;
            chr_nxt  = tok.chr;
          end
        end
        PH_CHECK: begin
          if (tok.cls == CLS_AMP) begin
            phase_nxt  = PH_IDLE;
            kind_nxt   = (check_r == {2'b00, sum_r}) ? KIND_ACCEPT : KIND_REJECT;
            ocount_nxt = verdict_count;
            good_nxt   = verdict_good;
          end else if (!done_r && tok.cls == CLS_DIGIT) begin
            check_nxt = (check_mul > 14'(CHECK_MAX)) ?
                        CHECK_W'(CHECK_MAX) : check_mul[CHECK_W-1:0];
          end else begin
            done_nxt = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      matched_r   <= 1'b1;
      sum_r       <= '0;
      check_r     <= '0;
      done_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        matched_r   <= matched_nxt;
        sum_r       <= sum_nxt;
        check_r     <= check_nxt;
        done_r      <= done_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        out_kind_r  <= kind_nxt;
        out_chr_r   <= chr_nxt;
        out_count_r <= ocount_nxt;
        out_good_r  <= good_nxt;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_verdict_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_ACCEPT || out_kind_r == KIND_REJECT)
      |-> out_chr_r == '0)
    else $error("verdict carries a character");

  a_char_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_NONE || out_kind_r == KIND_SEQ ||
                    out_kind_r == KIND_DATA)
      |-> out_count_r == '0 && !out_good_r)
    else $error("non-verdict item carries count or prefix flag");

  a_hash_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop && tok.cls == CLS_HASH |=> phase_r == PH_SEQ && count_r == '0)
    else $error("hash did not restart the frame");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    pop && tok.cls != CLS_HASH |=> count_r >= $past(count_r))
    else $error("data count went down inside a frame");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/text_frame_parser_sum_check.sv =====
// path: an accepted input item goes through the front token register, a queue entry and the back result register
// throughput: one item per cycle while out_tready does not stall the result, set by the frame update in the back end
// a 4-entry queue between classifier and frame engine absorbs short output stalls
// reset: rst_n synchronous active low; clears the queue, output valid and frame state
// (idle phase, prefix flag set, sum, check value, digit flag and data count zero)
`default_nettype none

module text_frame_parser_sum_check (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [19:8] data_count, [20] prefix_good
  output logic [2:0]       out_tuser   // [2:0] kind
);
  import tfp_pkg::*;

  // front -> queue
  logic     f_valid;
  logic     f_ready;
  tfp_tok_t f_tok;

  // queue -> back
  logic     q_valid;
  logic     q_ready;
  tfp_tok_t q_tok;

  // back result fields
  tfp_kind_t               r_kind;
  logic [CHAR_W-1:0]       r_chr;
  logic [DATA_COUNT_W-1:0] r_count;
  logic                    r_good;

  // classify each incoming character
  tfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_chr    (in_tdata),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  // decouples classification from the frame engine
  tfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_tok    (q_tok)
  );

  // frame state machine with registered result
  tfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (q_valid),
    .tok_ready (q_ready),
    .tok       (q_tok),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (r_kind),
    .res_chr   (r_chr),
    .res_count (r_count),
    .res_good  (r_good)
  );

  // pack result fields, low bits first, padded to whole bytes
  assign out_tdata = {3'b000, r_good, r_count, r_chr};
  assign out_tuser = r_kind;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb;
  import tfp_pkg::*;

  // timing and run shape
  localparam int HALF_PERIOD   = 1;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_REPORTS   = 10;

  // "NO=" packed with the first character in the lowest byte
  localparam logic [3*CHAR_W-1:0] PREFIX_TEXT = {CH_EQ, CH_O, CH_N};

  typedef enum logic [1:0] {
    FRM_IDLE,
    FRM_SEQ,
    FRM_DATA,
    FRM_CHECK
  } frame_phase_t;

  // one result item as the block should present it
  typedef struct packed {
    tfp_kind_t                kind;
    logic [CHAR_W-1:0]        chr;
    logic [DATA_COUNT_W-1:0]  count;
    logic                     good;
  } frame_result_t;

  // tracks the frame state of the stream and holds the results still owed by the block
  class frame_scoreboard;
    frame_phase_t           phase;
    logic [1:0]             prefix_pos;
    logic                   prefix_ok;
    logic [SUM_W-1:0]       byte_sum;
    logic [CHECK_W-1:0]     check_val;
    logic                   digits_end;
    logic [COUNT_BITS-1:0]  data_chars;
    frame_result_t          expected_results[$];
    int                     mismatches;
    int                     results_seen;
    int                     accepted_frames;
    int                     rejected_frames;
    bit                     count_capped;
    bit                     check_capped;

    function new();
      phase           = FRM_IDLE;
      mismatches      = 0;
      results_seen    = 0;
      accepted_frames = 0;
      rejected_frames = 0;
      count_capped    = 1'b0;
      check_capped    = 1'b0;
      clear_frame();
    endfunction

    function void clear_frame();
      prefix_pos = '0;
      prefix_ok  = 1'b1;
      byte_sum   = '0;
      check_val  = '0;
      digits_end = 1'b0;
      data_chars = '0;
    endfunction

    // verdict on an ampersand, frame goes back to idle
    function frame_result_t frame_verdict(bit pass);
      frame_result_t r;
      if (pass) begin
        r.kind = KIND_ACCEPT;
      end else begin
        r.kind = KIND_REJECT;
      end
      r.chr   = '0;
      r.count = (int'(data_chars) > OUT_COUNT_MAX) ? DATA_COUNT_W'(OUT_COUNT_MAX)
                                                   : DATA_COUNT_W'(data_chars);
      r.good  = prefix_ok && (prefix_pos == PREFIX_LEN);
      phase   = FRM_IDLE;
      return r;
    endfunction

    function frame_result_t step_char(logic [CHAR_W-1:0] c);
      frame_result_t r;
      int acc;
      r.kind  = KIND_NONE;
      r.chr   = '0;
      r.count = '0;
      r.good  = 1'b0;
      // a hash restarts the frame wherever it falls
      if (c == CH_HASH) begin
        clear_frame();
        phase = FRM_SEQ;
        return r;
      end
      case (phase)
        FRM_SEQ: begin
          if (c == CH_AMP) begin
            r = frame_verdict(1'b0);
          end else if (c == CH_LBRACE) begin
            if (prefix_pos < PREFIX_LEN) prefix_ok = 1'b0;
            phase = FRM_DATA;
          end else if (prefix_pos < PREFIX_LEN) begin
            if (c != PREFIX_TEXT[int'(prefix_pos)*CHAR_W +: CHAR_W]) prefix_ok = 1'b0;
            prefix_pos = prefix_pos + 2'd1;
          end else begin
            r.kind = KIND_SEQ;
            r.chr  = c;
          end
        end
        FRM_DATA: begin
          if (c == CH_AMP) begin
            r = frame_verdict(1'b0);
          end else if (c == CH_RBRACE) begin
            phase = FRM_CHECK;
          end else begin
            byte_sum = byte_sum + c;
            if (data_chars != '1) begin
              data_chars = data_chars + 1'b1;
            end else begin
              count_capped = 1'b1;
            end
            r.kind = KIND_DATA;
            r.chr  = c;
          end
        end
        FRM_CHECK: begin
          if (c == CH_AMP) begin
            r = frame_verdict(check_val == {2'b00, byte_sum});
          end else if (!digits_end && c >= CH_ZERO && c <= CH_NINE) begin
            acc = int'(check_val) * 10 + int'(c) - int'(CH_ZERO);
            if (acc > CHECK_MAX) begin
              acc          = CHECK_MAX;
              check_capped = 1'b1;
            end
            check_val = CHECK_W'(acc);
          end else begin
            digits_end = 1'b1;
          end
        end
        default: phase = FRM_IDLE;
      endcase
      return r;
    endfunction

    // every accepted input item owes exactly one result item
    function void note_byte(logic [CHAR_W-1:0] c);
      expected_results.push_back(step_char(c));
    endfunction

    function void check_result(logic [2:0] kind_bits, logic [23:0] tdata);
      frame_result_t want;
      logic [7:0]  got_chr;
      logic [11:0] got_cnt;
      logic        got_good;
      logic [2:0]  got_pad;
      got_chr  = tdata[7:0];
      got_cnt  = tdata[19:8];
      got_good = tdata[20];
      got_pad  = tdata[23:21];
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d with nothing expected: kind %0d tdata %h",
                   results_seen, kind_bits, tdata);
        return;
      end
      want = expected_results.pop_front();
      if (kind_bits !== want.kind || got_chr !== want.chr || got_cnt !== want.count ||
          got_good !== want.good || got_pad !== 3'b000) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result %0d: expected kind %0d byte %h count %0d good %b, ",
                    "got kind %0d byte %h count %0d good %b pad %b"},
                   results_seen, want.kind, want.chr, want.count, want.good,
                   kind_bits, got_chr, got_cnt, got_good, got_pad);
      end else if (want.kind == KIND_ACCEPT) begin
        accepted_frames++;
      end else if (want.kind == KIND_REJECT) begin
        rejected_frames++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  // block ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  frame_scoreboard sb;

  // sender bookkeeping
  int   burst_left = 0;
  int   items_sent = 0;
  logic hold_req   = 1'b0;   // asks the receiver for its long hold-off

  // receiver bookkeeping
  int   ready_mode = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  bit   hold_taken = 1'b0;

  int   cycle_count = 0;

  text_frame_parser_sum_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, sb.pending());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // both handshakes sampled at the edge, input side first
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
    end
  end

  // receiver: random stall modes, plus one long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 160);
      end
      mode_left--;
      case (ready_mode)
        0:       out_tready <= 1'b1;                        // no stalls
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
        default: out_tready <= ((mode_left % 8) < 5);        // periodic
      endcase
    end
  end

  // offer one item, idling first when the current burst is used up
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // random character that cannot end or restart the field it sits in
  function automatic logic [7:0] pick_char(input logic [7:0] bar);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_HASH || c == CH_AMP || c == bar);
    return c;
  endfunction

  // mostly well-formed frames with random content; some broken, some noise after
  task automatic send_random_frame();
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    logic [7:0] c;
    int         style;
    int         n;
    int         cut;
    string      digits;
    sum = '0;
    frame_q.push_back(CH_HASH);
    if ($urandom_range(0, 4) != 0) begin
      frame_q.push_back(CH_N);
      frame_q.push_back(CH_O);
      frame_q.push_back(CH_EQ);
    end else begin
      // short or wrong prefix
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1) == 0) frame_q.push_back(PREFIX_TEXT[i*CHAR_W +: CHAR_W]);
        else frame_q.push_back(pick_char(CH_LBRACE));
      end
    end
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      // a close brace now and then inside the sequence field
      if ($urandom_range(0, 7) == 0) frame_q.push_back(CH_RBRACE);
      else frame_q.push_back(pick_char(CH_LBRACE));
    end
    frame_q.push_back(CH_LBRACE);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(0, 9) == 0) ? CH_LBRACE : pick_char(CH_RBRACE);
      sum = sum + c;
      frame_q.push_back(c);
    end
    frame_q.push_back(CH_RBRACE);
    style = $urandom_range(0, 9);
    case (style)
      0:       digits = $sformatf("%0d", (int'(sum) + $urandom_range(1, 255)) % 256);
      1:       digits = $sformatf("%0d", $urandom_range(1024, 99999));  // saturates
      2:       digits = "";
      3:       digits = {$sformatf("%0d", sum), "x7"};  // digits after a non-digit ignored
      4:       digits = {"00", $sformatf("%0d", sum)};
      5:       digits = {" ", $sformatf("%0d", sum)};   // non-digit before any digit
      default: digits = $sformatf("%0d", sum);
    endcase
    for (int i = 0; i < digits.len(); i++) frame_q.push_back(digits[i]);
    frame_q.push_back(CH_AMP);
    // broken frame: cut short, sometimes closed by an early ampersand
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
      if ($urandom_range(0, 1) == 0) frame_q.push_back(CH_AMP);
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
    // noise between frames, any byte value
    n = $urandom_range(0, 2);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    bit         paused;
    paused    = 1'b0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_byte("x");              // outside a frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("#NO=7{A}65&");    // good frame, accepted
    send_text("#NO=}{{#N{&");    // close brace as seq char, open brace as data, hash restart,
                                 // short prefix and ampersand in data
    send_text("#&");             // ampersand in the sequence field
    send_text("#{9}5x7&");       // non-digit ends the number, no prefix at all

    // random part
    while (items_sent < RANDOM_ITEMS) begin
      send_random_frame();
      if (!hold_req && items_sent > 300) hold_req <= 1'b1;
      if (!paused && items_sent > 600) begin
        // let the block run dry before going on
        paused = 1'b1;
        in_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d items in, %0d results checked, %0d frames accepted, %0d rejected",
             items_sent, sb.results_seen, sb.accepted_frames, sb.rejected_frames);
    $display("run: data count cap hit %0d, check value cap hit %0d, long output stall %0d",
             sb.count_capped, sb.check_capped, hold_taken);
    if (sb.mismatches != 0) $display("%0d mismatching results", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/tfp_pkg.sv
rtl/core/tfp_front.sv
rtl/core/tfp_queue.sv
rtl/core/tfp_back.sv
rtl/core/text_frame_parser_sum_check.sv
test/tb.sv
